@@ design/lsfb_pkg.sv @@
package lsfb_pkg;

	localparam logic [1:0] FMT_SERIAL = 2'd0;
	localparam logic [1:0] FMT_PIXCTL = 2'd1;
	localparam logic [1:0] FMT_EXT    = 2'd2;
	localparam logic [1:0] FMT_UNUSED = 2'd3;

	localparam logic [1:0] REG_FORMAT  = 2'd0;
	localparam logic [1:0] REG_COUNT   = 2'd1;
	localparam logic [1:0] REG_CHANNEL = 2'd2;

	localparam int CNT_W = 14;

	localparam logic [7:0] MAGIC_0      = 8'h41;
	localparam logic [7:0] MAGIC_1      = 8'h64;
	localparam logic [7:0] MAGIC_2      = 8'h61;
	localparam logic [7:0] CHECK_XOR    = 8'h55;
	localparam logic [7:0] CMD_PIXCTL   = 8'h00;
	localparam logic [7:0] CMD_EXT      = 8'hFF;
	localparam logic [7:0] SYSID_HI     = 8'h0B;
	localparam logic [7:0] SYSID_LO     = 8'h0B;

	// byte slots: header in 0..5, pixel bytes in 6..9
	localparam logic [3:0] SLOT_HDR_LONG  = 4'd0;
	localparam logic [3:0] SLOT_HDR_SHORT = 4'd2;
	localparam logic [3:0] SLOT_RED       = 4'd6;
	localparam logic [3:0] SLOT_GREEN     = 4'd7;
	localparam logic [3:0] SLOT_BLUE      = 4'd8;
	localparam logic [3:0] SLOT_ALPHA     = 4'd9;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	typedef struct packed {
		logic [1:0]       fmt;
		logic [CNT_W-1:0] count;
		logic [7:0]       chan;
	} cfg_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic [1:0]  fmt;
		logic [3:0]  first_slot;
		logic        frame_end;
		logic [7:0]  chan;
		logic [7:0]  hdr_hi;
		logic [7:0]  hdr_lo;
	} desc_t;

endpackage

@@ design/lsfb_front.sv @@
module lsfb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [31:0]    s_tdata,
	input  lsfb_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           push,
	output lsfb_pkg::desc_t push_desc
);
	import lsfb_pkg::*;

	logic [CNT_W-1:0] pixels_done_q;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W:0]   done_p1;
	logic [15:0]      len_pc;
	logic [15:0]      len_ext;
	logic [1:0]       fmt;
	logic             first;
	logic             frame_end;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	assign fmt     = (cfg.fmt == FMT_UNUSED) ? FMT_SERIAL : cfg.fmt;
	assign cnt     = (cfg.count == '0) ? CNT_W'(1) : cfg.count;
	assign cnt_m1  = cnt - CNT_W'(1);
	assign len_pc  = {1'b0, cnt, 1'b0} + {2'b00, cnt};
	assign len_ext = {cnt, 2'b10};
	assign first   = (pixels_done_q == '0);
	assign done_p1 = {1'b0, pixels_done_q} + (CNT_W+1)'(1);
	assign frame_end = (done_p1 >= {1'b0, cnt});

	always_comb begin
		push_desc.pixel     = s_tdata;
		push_desc.fmt       = fmt;
		push_desc.frame_end = frame_end;
		push_desc.chan      = cfg.chan;
		push_desc.first_slot = SLOT_RED;
		if (first) begin
			push_desc.first_slot = (fmt == FMT_PIXCTL) ? SLOT_HDR_SHORT : SLOT_HDR_LONG;
		end
		unique case (fmt)
			FMT_PIXCTL: begin
				push_desc.hdr_hi = len_pc[15:8];
				push_desc.hdr_lo = len_pc[7:0];
			end
			FMT_EXT: begin
				push_desc.hdr_hi = len_ext[15:8];
				push_desc.hdr_lo = len_ext[7:0];
			end
			default: begin
				push_desc.hdr_hi = {2'b00, cnt_m1[13:8]};
				push_desc.hdr_lo = cnt_m1[7:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_done_q <= '0;
		end else if (push) begin
			pixels_done_q <= frame_end ? '0 : done_p1[CNT_W-1:0];
		end
	end

endmodule

@@ design/lsfb_fifo.sv @@
module lsfb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsfb_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output lsfb_pkg::desc_t pop_desc
);
	import lsfb_pkg::*;

	desc_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full     = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

@@ design/lsfb_back.sv @@
module lsfb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  lsfb_pkg::desc_t q_desc,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	output logic            m_tuser
);
	import lsfb_pkg::*;

	desc_t      desc_q;
	logic [3:0] slot_q;
	logic       busy_q;
	logic       m_tvalid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       eof_q;
	logic       advance;
	logic       is_last;
	logic [3:0] last_slot;
	logic [7:0] cur_byte;
	logic [7:0] check;
	logic       ser;
	logic       pc;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = eof_q;

	assign advance   = !m_tvalid_q || m_tready;
	assign last_slot = (desc_q.fmt == FMT_EXT) ? SLOT_ALPHA : SLOT_BLUE;
	assign is_last   = (slot_q == last_slot);
	assign pop       = q_valid && (!busy_q || (advance && is_last));
	assign check     = desc_q.hdr_hi ^ desc_q.hdr_lo ^ CHECK_XOR;
	assign ser       = (desc_q.fmt == FMT_SERIAL);
	assign pc        = (desc_q.fmt == FMT_PIXCTL);

	always_comb begin
		case (slot_q)
			4'd0: cur_byte = ser ? MAGIC_0 : desc_q.chan;
			4'd1: cur_byte = ser ? MAGIC_1 : CMD_EXT;
			4'd2: cur_byte = ser ? MAGIC_2 : (pc ? desc_q.chan : desc_q.hdr_hi);
			4'd3: cur_byte = ser ? desc_q.hdr_hi : (pc ? CMD_PIXCTL : desc_q.hdr_lo);
			4'd4: cur_byte = ser ? desc_q.hdr_lo : (pc ? desc_q.hdr_hi : SYSID_HI);
			4'd5: cur_byte = ser ? check : (pc ? desc_q.hdr_lo : SYSID_LO);
			SLOT_RED:   cur_byte = desc_q.pixel[31:24];
			SLOT_GREEN: cur_byte = desc_q.pixel[23:16];
			SLOT_BLUE:  cur_byte = desc_q.pixel[15:8];
			SLOT_ALPHA: cur_byte = desc_q.pixel[7:0];
			default:    cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				m_tvalid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= q_desc;
			slot_q <= q_desc.first_slot;
		end else if (advance && busy_q) begin
			slot_q <= slot_q + 4'd1;
		end
		if (advance) begin
			byte_q <= cur_byte;
			last_q <= is_last;
			eof_q  <= is_last && desc_q.frame_end;
		end
	end

endmodule

@@ design/led_strip_frame_builder_unit.sv @@
// channel  | dir | handshake          | payload
// s_*      | in  | tvalid/tready      | tdata[31:0] pixel_word
// m_*      | out | tvalid/tready      | tdata[7:0] out_byte, tlast, tuser
// apb      | in  | psel/penable/pready| paddr[3:0], pwdata/prdata[31:0]
//
// One byte leaves per cycle, m_tready and queue allowing: a pixel is 3 or
// 4 bytes, plus 4 or 6 header bytes per frame; the byte sequencer sets this.
// Pixels are queued four deep ahead of the sequencer and the output register.
// Reset clears registers to serial format, count 1, channel 0, frame start.
// A stalled m_tready holds the byte; s_tready drops only when the queue fills.
module led_strip_frame_builder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] pixel_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] end_of_frame
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lsfb_pkg::*;

	cfg_t  cfg_q;
	desc_t push_desc;
	desc_t pop_desc;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_valid;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt   <= FMT_SERIAL;
			cfg_q.count <= CNT_W'(1);
			cfg_q.chan  <= 8'h00;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_FORMAT:  cfg_q.fmt   <= pwdata[1:0];
				REG_COUNT:   cfg_q.count <= pwdata[CNT_W-1:0];
				REG_CHANNEL: cfg_q.chan  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FORMAT:  prdata = {30'd0, cfg_q.fmt};
			REG_COUNT:   prdata = {{(32-CNT_W){1'b0}}, cfg_q.count};
			REG_CHANNEL: prdata = {24'd0, cfg_q.chan};
			default:     prdata = 32'd0;
		endcase
	end

	lsfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	lsfb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_desc  (pop_desc)
	);

	lsfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_desc   (pop_desc),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ design/lsfb_checker.sv @@
module lsfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser,
	input logic [31:0] prdata
);

	// end of frame only on the last byte of a pixel
	a_eof_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end of frame without last");

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid in reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
		&& $stable(m_tlast) && $stable(m_tuser))
		else $error("stalled output transaction changed");

	// no register is wider than the pixel count
	a_readback_width: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:14] == 18'd0)
		else $error("readback upper bits set");

endmodule

bind led_strip_frame_builder_unit lsfb_checker u_lsfb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.prdata   (prdata)
);
